[rtl/sem_pkg.sv]
// Shared types, constants and state codes of the Sobel edge magnitude block.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int NUM_CH        = 3;
  localparam int PIX_W         = 8;
  localparam int RGB_W         = NUM_CH * PIX_W;
  localparam int GRAD_W        = 11;
  localparam int SUM_W         = 21;
  localparam int ROOT_STEPS    = (SUM_W + 1) / 2;
  localparam int STEP_W        = $clog2(ROOT_STEPS);
  localparam int PIX_MAX       = 255;

  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int IMG_W_W       = 12;
  localparam int IMG_H_W       = 13;
  localparam int OUT_ROW_W     = 12;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(480);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = CFG_ADDR_W'(1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  // Status of the magnitude unit
  typedef struct packed {
    logic busy;
    logic done;
  } mag_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_GRAD,
    ST_SQR,
    ST_ROOT,
    ST_SEND
  } sem_state_t;

endpackage

[rtl/sem_if.sv]
// Stream and configuration channel interfaces of the Sobel edge magnitude block.
`timescale 1ns / 1ps
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, func, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

interface sem_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [12:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/sem_mag.sv]
// Three-channel rounded square root with saturation, computed by a digit recurrence.
`timescale 1ns / 1ps
module sem_mag
  import sem_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  sum_t     sq_sum [NUM_CH],
  output mag_sts_t sts,
  output pix_t     mag [NUM_CH]
);

  sum_t                 rem_r  [NUM_CH];
  sum_t                 root_r [NUM_CH];
  logic [STEP_W-1:0]    step_r;
  logic                 busy_r;
  logic                 done_r;
  sum_t                 bit_c;
  logic [SUM_W:0]       trial_c [NUM_CH];
  logic [SUM_W:0]       rnd_c   [NUM_CH];

  // Current test bit: 4^(steps left)
  always_comb begin
    bit_c = SUM_W'(1) << (5'(2) * (5'(ROOT_STEPS - 1) - 5'(step_r)));
    for (int ch = 0; ch < NUM_CH; ch++) begin
      trial_c[ch] = {1'b0, root_r[ch]} + {1'b0, bit_c};
    end
  end

  // Iterate the digit recurrence on all channels together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (start) begin
        rem_r[ch]  <= sq_sum[ch];
        root_r[ch] <= '0;
      end else if (busy_r) begin
        if ({1'b0, rem_r[ch]} >= trial_c[ch]) begin
          rem_r[ch]  <= rem_r[ch] - trial_c[ch][SUM_W-1:0];
          root_r[ch] <= (root_r[ch] >> 1) + bit_c;
        end else begin
          root_r[ch] <= root_r[ch] >> 1;
        end
      end
    end
  end

  // Round up when the remainder exceeds the root, then saturate
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      rnd_c[ch] = {1'b0, root_r[ch]} + (SUM_W+1)'(rem_r[ch] > root_r[ch]);
      mag[ch]   = (rnd_c[ch] > (SUM_W+1)'(PIX_MAX)) ? PIX_W'(PIX_MAX) : rnd_c[ch][PIX_W-1:0];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

[rtl/sobel_edge_magnitude_rgb_top.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels.
// Pixels enter in raster order, one transaction at a time. An input that yields
// no result passes through accept with line store read, then write-back and
// window shift. An input that yields a result passes through accept, write-back,
// kernels, squares, the shared root unit (11 digit steps for all three channels,
// then the wait to see it done), then the output register load. The load
// waits while an earlier result still sits in the output register, and the input
// stays blocked meanwhile. Output pixel n leaves on the input transaction n+W+1,
// so after the last pixel feed W+1 flush items. Both line stores live in one
// memory of MAX_WIDTH entries, 48 bits wide; no clearing pass runs after reset.
// Configuration writes are taken only while no transaction is in flight; a write
// to either register restarts the frame.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb_top
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  sem_pix_if.sink   in_ch,
  sem_res_if.source out_ch,
  sem_cfg_if.sink   cfg_ch
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);

  sem_state_t state_r, state_nxt;

  logic [IMG_W_W-1:0]   img_w_r;
  logic [IMG_H_W-1:0]   img_h_r;
  logic [CNT_W-1:0]     eff_w;
  logic [IMG_H_W-1:0]   eff_h;

  logic [COL_W-1:0]     in_col_r;
  logic [IMG_H_W-1:0]   in_row_r;
  logic [COL_W-1:0]     out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;

  logic [RGB_W-1:0]     pix_r;
  logic [2*RGB_W-1:0]   line_mem [MAX_WIDTH];
  logic [2*RGB_W-1:0]   rd_r;
  logic [RGB_W-1:0]     win_r [3][3];

  logic                 in_acc, cfg_acc, out_acc;
  logic                 has_res;
  logic                 last_c, last_r;
  logic                 row_ok [3];
  logic                 col_ok [3];
  logic signed [GRAD_W-1:0]   pv [NUM_CH][3][3];
  logic signed [GRAD_W-1:0]   gx_c [NUM_CH];
  logic signed [GRAD_W-1:0]   gy_c [NUM_CH];
  logic signed [GRAD_W-1:0]   gx_r [NUM_CH];
  logic signed [GRAD_W-1:0]   gy_r [NUM_CH];
  logic signed [2*GRAD_W-1:0] px_c [NUM_CH];
  logic signed [2*GRAD_W-1:0] py_c [NUM_CH];
  sum_t                 sq_c [NUM_CH];
  pix_t                 mag  [NUM_CH];
  mag_sts_t             mag_sts;
  logic                 mag_start;
  logic                 load_out;

  logic                 out_vld_r;
  pix_t                 out_r_r, out_g_r, out_b_r;
  logic                 out_end_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = (state_r == ST_IDLE);

  // Effective frame size: zero acts as one, width clamps to the store depth
  always_comb begin
    if (img_w_r == '0) begin
      eff_w = CNT_W'(1);
    end else if (32'(img_w_r) > 32'(MAX_WIDTH)) begin
      eff_w = CNT_W'(MAX_WIDTH);
    end else begin
      eff_w = CNT_W'(img_w_r);
    end
    eff_h = (img_h_r == '0) ? IMG_H_W'(1) : img_h_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_READ;
      ST_READ: state_nxt = has_res ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_ROOT;
      ST_ROOT: if (mag_sts.done) state_nxt = ST_SEND;
      ST_SEND: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mag_start   = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SQR:  mag_start   = 1'b1;
      ST_SEND: load_out    = !out_vld_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // A window becomes complete once the center pixel has a right and lower neighbor
  assign has_res = (in_row_r >= IMG_H_W'(2)) ||
                   (in_row_r == IMG_H_W'(1) && in_col_r != '0);

  // Hold the incoming pixel; flush items enter as black
  always_ff @(posedge clk) begin
    if (in_acc) pix_r <= in_ch.func ? '0 : {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
  end

  // Line stores: read at accept, write back upper <= lower, lower <= pixel
  always_ff @(posedge clk) begin
    if (in_acc) rd_r <= line_mem[in_col_r];
    if (state_r == ST_READ) line_mem[in_col_r] <= {rd_r[RGB_W-1:0], pix_r};
  end

  // Advance the window by one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) win_r[j][k] <= '0;
      end
    end else if (state_r == ST_READ) begin
      for (int j = 0; j < 3; j++) begin
        win_r[j][0] <= win_r[j][1];
        win_r[j][1] <= win_r[j][2];
      end
      win_r[0][2] <= rd_r[2*RGB_W-1:RGB_W];
      win_r[1][2] <= rd_r[RGB_W-1:0];
      win_r[2][2] <= pix_r;
    end
  end

  // Border masks and frame end for the current output position
  always_comb begin
    row_ok[0] = out_row_r != '0;
    row_ok[1] = 1'b1;
    row_ok[2] = (14'(out_row_r) + 14'd1) < 14'(eff_h);
    col_ok[0] = out_col_r != '0;
    col_ok[1] = 1'b1;
    col_ok[2] = (32'(out_col_r) + 32'd1) < 32'(eff_w);
    last_c    = !row_ok[2] && !col_ok[2];
  end

  // Sobel kernels per channel
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pv[ch][j][k] = (row_ok[j] && col_ok[k]) ?
                         GRAD_W'(win_r[j][k][PIX_W*(NUM_CH-1-ch) +: PIX_W]) : '0;
        end
      end
      gx_c[ch] = (pv[ch][0][2] + (pv[ch][1][2] <<< 1) + pv[ch][2][2]) -
                 (pv[ch][0][0] + (pv[ch][1][0] <<< 1) + pv[ch][2][0]);
      gy_c[ch] = (pv[ch][2][0] + (pv[ch][2][1] <<< 1) + pv[ch][2][2]) -
                 (pv[ch][0][0] + (pv[ch][0][1] <<< 1) + pv[ch][0][2]);
      px_c[ch] = gx_r[ch] * gx_r[ch];
      py_c[ch] = gy_r[ch] * gy_r[ch];
      sq_c[ch] = SUM_W'(px_c[ch]) + SUM_W'(py_c[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_GRAD) begin
      gx_r   <= gx_c;
      gy_r   <= gy_c;
      last_r <= last_c;
    end
  end

  // Frame position counters
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_acc) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (state_r == ST_READ) begin
      if ((32'(in_col_r) + 32'd1) >= 32'(eff_w)) begin
        in_col_r <= '0;
        in_row_r <= in_row_r + IMG_H_W'(1);
      end else begin
        in_col_r <= in_col_r + COL_W'(1);
      end
    end else if (state_r == ST_GRAD) begin
      if (last_c) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else if (!col_ok[2]) begin
        out_col_r <= '0;
        out_row_r <= out_row_r + OUT_ROW_W'(1);
      end else begin
        out_col_r <= out_col_r + COL_W'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= WIDTH_RESET;
      img_h_r <= HEIGHT_RESET;
    end else if (cfg_acc) begin
      case (cfg_ch.addr)
        REG_WIDTH:  img_w_r <= cfg_ch.data[IMG_W_W-1:0];
        REG_HEIGHT: img_h_r <= cfg_ch.data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  sem_mag u_mag (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mag_start),
    .sq_sum (sq_c),
    .sts    (mag_sts),
    .mag    (mag)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_acc) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r_r   <= mag[0];
      out_g_r   <= mag[1];
      out_b_r   <= mag[2];
      out_end_r <= last_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_red   = out_r_r;
  assign out_ch.out_green = out_g_r;
  assign out_ch.out_blue  = out_b_r;
  assign out_ch.frame_end = out_end_r;

  // The root unit only runs while the sequencer waits for it
  a_mag_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mag_sts.busy |-> state_r == ST_ROOT)
    else $error("root unit busy outside its wait state");

  // A pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_vld_r || out_ch.ready))
    else $error("output register overwritten");

  // The frame's last result restarts all position counters
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GRAD && last_c && !cfg_acc) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("counters not cleared at frame end");

  // Items without a result return to idle right after the write-back
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && !has_res) |=> state_r == ST_IDLE)
    else $error("item without result did not finish");

endmodule
